// ----- src/svpd_pkg.sv -----
// ============================================================================
// svpd_pkg
// Shared constants, register indexes and status types of the space vector
// PWM duty core.
// ============================================================================
`default_nettype none

package svpd_pkg;

    localparam int VOLT_WIDTH_DEF  = 16;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CORDIC_STEPS    = 28;
    localparam int BUS_RESET       = 2150;

    localparam logic [CFG_IDX_W-1:0] REG_BUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd1;

    localparam logic [15:0] MOD_LIMIT   = 16'd37814;
    localparam logic [31:0] CORDIC_GAIN = 32'd652032874;
    localparam logic [30:0] SQRT3_Q30   = 31'd1859775393;
    localparam logic [31:0] RECIP3      = 32'hAAAAAAAB;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] val;
        begin
            case (idx)
                5'd0:    val = 32'd536870912;
                5'd1:    val = 32'd316933406;
                5'd2:    val = 32'd167458907;
                5'd3:    val = 32'd85004756;
                5'd4:    val = 32'd42667331;
                5'd5:    val = 32'd21354465;
                5'd6:    val = 32'd10679838;
                5'd7:    val = 32'd5340245;
                5'd8:    val = 32'd2670163;
                5'd9:    val = 32'd1335087;
                5'd10:   val = 32'd667544;
                5'd11:   val = 32'd333772;
                5'd12:   val = 32'd166886;
                5'd13:   val = 32'd83443;
                5'd14:   val = 32'd41722;
                5'd15:   val = 32'd20861;
                5'd16:   val = 32'd10430;
                5'd17:   val = 32'd5215;
                5'd18:   val = 32'd2608;
                5'd19:   val = 32'd1304;
                5'd20:   val = 32'd652;
                5'd21:   val = 32'd326;
                5'd22:   val = 32'd163;
                5'd23:   val = 32'd81;
                5'd24:   val = 32'd41;
                5'd25:   val = 32'd20;
                5'd26:   val = 32'd10;
                5'd27:   val = 32'd5;
                default: val = 32'd0;
            endcase
            return val;
        end
    endfunction

endpackage

`default_nettype wire

// ----- src/space_vector_pwm_duty_core.sv -----
// ============================================================================
// space_vector_pwm_duty_core
// Space vector PWM duty generator: d/q command and rotor angle in, three
// centered compare values and the sector out.
//
// Channel   Direction  Handshake            Payload
// command   in         start / busy         q_voltage, d_voltage, electrical_angle
// result    out        done (one cycle)     duty_a, duty_b, duty_c, sector
// config    in         cfg_write            cfg_index, cfg_data
//
// The engine handles one beat at a time, through the two-step-per-cycle square root
// and CORDIC loop followed by the divider loop.
// A front stage and a two-entry queue take new beats while the engine works;
// busy rises only when both are full. The result receiver cannot stall.
// Reset clears the control state and loads the bus register with 2150.
// ============================================================================
`default_nettype none

module space_vector_pwm_duty_core
    import svpd_pkg::*;
#(
    parameter int VOLT_WIDTH  = VOLT_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int CFG_W       = (VOLT_WIDTH > 16) ? VOLT_WIDTH : 16
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [VOLT_WIDTH-1:0]  q_voltage,
    input  wire logic signed [VOLT_WIDTH-1:0]  d_voltage,
    input  wire logic        [ANGLE_WIDTH-1:0] electrical_angle,
    input  wire logic                          cfg_write,
    input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [CFG_W-1:0]       cfg_data,
    output logic                               done,
    output logic             [15:0]            duty_a,
    output logic             [15:0]            duty_b,
    output logic             [15:0]            duty_c,
    output logic             [2:0]             sector
);

    localparam int ITEM_W = 4 * VOLT_WIDTH + ANGLE_WIDTH + 1;

    logic [VOLT_WIDTH-1:0] bus_reg;
    logic [15:0]           period_reg;
    q_status_t             qstat;
    logic                  push;
    logic [ITEM_W-1:0]     push_data;
    logic                  pop;
    logic [ITEM_W-1:0]     pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_reg    <= VOLT_WIDTH'(BUS_RESET);
            period_reg <= 16'd0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_BUS)
            begin
                bus_reg <= cfg_data[VOLT_WIDTH-1:0];
            end
            else if (cfg_index == REG_PERIOD)
            begin
                period_reg <= cfg_data[15:0];
            end
        end
    end

    svpd_front #(
        .VOLT_WIDTH  (VOLT_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .ITEM_W      (ITEM_W)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .q_voltage        (q_voltage),
        .d_voltage        (d_voltage),
        .electrical_angle (electrical_angle),
        .qstat            (qstat),
        .push             (push),
        .push_data        (push_data)
    );

    svpd_queue #(
        .ITEM_W (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .qstat     (qstat),
        .pop_data  (pop_data)
    );

    svpd_engine #(
        .VOLT_WIDTH  (VOLT_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .ITEM_W      (ITEM_W)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .bus_voltage  (bus_reg),
        .timer_reload (period_reg),
        .qstat        (qstat),
        .pop_data     (pop_data),
        .pop          (pop),
        .done         (done),
        .duty_a       (duty_a),
        .duty_b       (duty_b),
        .duty_c       (duty_c),
        .sector       (sector)
    );

`ifndef SYNTHESIS
    a_sector_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (sector >= 3'd1 && sector <= 3'd6))
        else $error("sector out of range");

    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("back-to-back result strobes");

    a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
        (done && period_reg == 16'd0) |-> (duty_a == 16'd0 && duty_b == 16'd0 && duty_c == 16'd0))
        else $error("nonzero duty with zero period");

    a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (qstat.full && !pop) |=> busy || !$past(push) || qstat.full)
        else $error("queue overflow");
`endif

endmodule

`default_nettype wire

// ----- src/svpd_front.sv -----
// ============================================================================
// svpd_front
// Command front end: takes a beat, forms the squared vector length and the
// zero-command flag, and hands the beat to the queue.
// ============================================================================
`default_nettype none

module svpd_front
    import svpd_pkg::*;
#(
    parameter int VOLT_WIDTH  = VOLT_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int ITEM_W      = 4 * VOLT_WIDTH + ANGLE_WIDTH + 1
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [VOLT_WIDTH-1:0]  q_voltage,
    input  wire logic signed [VOLT_WIDTH-1:0]  d_voltage,
    input  wire logic        [ANGLE_WIDTH-1:0] electrical_angle,
    input  wire q_status_t                     qstat,
    output logic                               push,
    output logic             [ITEM_W-1:0]      push_data
);

    logic                           fv_reg;
    logic                           fv_next;
    logic [ITEM_W-1:0]              item_reg;
    logic                           accept;
    logic signed [2*VOLT_WIDTH-1:0] qq;
    logic signed [2*VOLT_WIDTH-1:0] dd;
    logic        [2*VOLT_WIDTH-1:0] len_sq;
    logic                           zero_cmd;

    assign busy      = fv_reg && qstat.full;
    assign accept    = start && !busy;
    assign push      = fv_reg && !qstat.full;
    assign push_data = item_reg;

    assign qq       = q_voltage * q_voltage;
    assign dd       = d_voltage * d_voltage;
    assign len_sq   = $unsigned(qq) + $unsigned(dd);
    assign zero_cmd = (q_voltage == '0) && (d_voltage == '0);

    always_comb
    begin
        fv_next = fv_reg;
        if (accept)
        begin
            fv_next = 1'b1;
        end
        else if (push)
        begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= {q_voltage, d_voltage, electrical_angle, len_sq, zero_cmd};
        end
    end

endmodule

`default_nettype wire

// ----- src/svpd_queue.sv -----
// ============================================================================
// svpd_queue
// Two-entry queue between the command front end and the modulation engine.
// ============================================================================
`default_nettype none

module svpd_queue
    import svpd_pkg::*;
#(
    parameter int ITEM_W = 4 * VOLT_WIDTH_DEF + ANGLE_WIDTH_DEF + 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [ITEM_W-1:0] push_data,
    input  wire logic              pop,
    output q_status_t              qstat,
    output logic      [ITEM_W-1:0] pop_data
);

    logic [ITEM_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;

    assign qstat.empty = (count_reg == 2'd0);
    assign qstat.full  = (count_reg == 2'd2);
    assign pop_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/svpd_engine.sv -----
// ============================================================================
// svpd_engine
// Modulation engine: square root and vector angle, sector split, divider and
// sine CORDICs, then the timing products and the duty scaling.
// ============================================================================
`default_nettype none

module svpd_engine
    import svpd_pkg::*;
#(
    parameter int VOLT_WIDTH  = VOLT_WIDTH_DEF,
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
    parameter int ITEM_W      = 4 * VOLT_WIDTH + ANGLE_WIDTH + 1
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [VOLT_WIDTH-1:0]  bus_voltage,
    input  wire logic [15:0]            timer_reload,
    input  wire q_status_t              qstat,
    input  wire logic [ITEM_W-1:0]      pop_data,
    output logic                        pop,
    output logic                        done,
    output logic      [15:0]            duty_a,
    output logic      [15:0]            duty_b,
    output logic      [15:0]            duty_c,
    output logic      [2:0]             sector
);

    localparam int VW       = VOLT_WIDTH;
    localparam int AW       = ANGLE_WIDTH;
    localparam int RW       = VW + 8;
    localparam int SQ_STEPS = VW + 8;
    localparam int RAD_W    = 2 * VW + 16;
    localparam int RMW      = RW + 3;
    localparam int DIVN     = VW + 16;
    localparam int XW       = VW + 11;
    localparam int SW       = 34;
    localparam int ROOT_N   = (SQ_STEPS > CORDIC_STEPS) ? SQ_STEPS : CORDIC_STEPS;
    localparam int CW       = $clog2(DIVN + 3);

    localparam logic [31:0] PHI_RND = 32'd1 << (31 - AW);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ROOT = 9'b000000010,
        S_ANG  = 9'b000000100,
        S_RECP = 9'b000001000,
        S_DIV  = 9'b000010000,
        S_M1   = 9'b000100000,
        S_M2   = 9'b001000000,
        S_M3   = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [RMW-1:0] rem;
        logic [RW-1:0]  root;
    } sq_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic        [31:0]   z;
    } at_t;

    typedef struct packed {
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        logic signed [SW-1:0] z;
    } sn_t;

    typedef struct packed {
        logic [VW-1:0] pr;
        logic          qbit;
    } dv_t;

    function automatic sq_t sqrt_step(input sq_t cur, input logic [1:0] bits2);
        sq_t            res;
        logic [RMW-1:0] rem2;
        logic [RMW-1:0] trial;
        begin
            rem2  = {cur.rem[RMW-3:0], bits2};
            trial = RMW'({cur.root, 2'b01});
            if (rem2 >= trial)
            begin
                res.rem  = rem2 - trial;
                res.root = {cur.root[RW-2:0], 1'b1};
            end
            else
            begin
                res.rem  = rem2;
                res.root = {cur.root[RW-2:0], 1'b0};
            end
            return res;
        end
    endfunction

    function automatic at_t atan_step(input at_t cur, input logic [4:0] idx);
        at_t                  res;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        begin
            xs = cur.x >>> idx;
            ys = cur.y >>> idx;
            if (!cur.y[XW-1] && (cur.y != '0))
            begin
                res.x = cur.x + ys;
                res.y = cur.y - xs;
                res.z = cur.z + atan_turn(idx);
            end
            else
            begin
                res.x = cur.x - ys;
                res.y = cur.y + xs;
                res.z = cur.z - atan_turn(idx);
            end
            return res;
        end
    endfunction

    function automatic sn_t sin_step(input sn_t cur, input logic [4:0] idx);
        sn_t                  res;
        logic signed [SW-1:0] xs;
        logic signed [SW-1:0] ys;
        logic signed [SW-1:0] at;
        begin
            xs = cur.x >>> idx;
            ys = cur.y >>> idx;
            at = $signed(SW'(atan_turn(idx)));
            if (!cur.z[SW-1])
            begin
                res.x = cur.x - ys;
                res.y = cur.y + xs;
                res.z = cur.z - at;
            end
            else
            begin
                res.x = cur.x + ys;
                res.y = cur.y - xs;
                res.z = cur.z + at;
            end
            return res;
        end
    endfunction

    function automatic dv_t div_step(input logic [VW-1:0] pr, input logic nbit,
                                     input logic [VW-1:0] dvs);
        dv_t         res;
        logic [VW:0] t;
        begin
            t = {pr, nbit};
            if (t >= {1'b0, dvs})
            begin
                res.pr   = VW'(t - {1'b0, dvs});
                res.qbit = 1'b1;
            end
            else
            begin
                res.pr   = t[VW-1:0];
                res.qbit = 1'b0;
            end
            return res;
        end
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [CW-1:0]    cnt_reg;
    logic [CW-1:0]    cnt_idx1;
    logic [RAD_W-1:0] rad_reg;
    sq_t              sq_reg;
    at_t              at_reg;
    logic             zero_reg;
    logic [AW-1:0]    ang_reg;
    logic [2:0]       sidx_reg;
    logic [31:0]      y1_reg;
    logic [31:0]      y2_reg;
    logic [DIVN-1:0]  dvd_reg;
    logic [VW-1:0]    pr_reg;
    sn_t              sn1_reg;
    sn_t              sn2_reg;
    logic [15:0]      r_reg;
    logic [30:0]      p1_reg;
    logic [30:0]      p2_reg;
    logic [16:0]      t1_reg;
    logic [16:0]      t2_reg;
    logic [17:0]      ta_reg;
    logic [17:0]      tb_reg;
    logic [17:0]      tc_reg;
    logic             done_reg;
    logic [15:0]      duty_a_reg;
    logic [15:0]      duty_b_reg;
    logic [15:0]      duty_c_reg;
    logic [2:0]       sector_reg;

    logic signed [VW-1:0] ld_q;
    logic signed [VW-1:0] ld_d;
    logic [AW-1:0]        ld_ang;
    logic [2*VW-1:0]      ld_s;
    logic                 ld_zero;
    logic signed [XW-1:0] ld_x;
    logic signed [XW-1:0] ld_y;

    logic e0_sq, e1_sq, e0_cd, e1_cd, e0_dv, e1_dv;
    sq_t  sq0, sq1;
    at_t  at0, at1;
    sn_t  s10, s11, s20, s21;
    dv_t  dv0, dv1;

    logic [31:0]   phi_sum;
    logic [AW-1:0] th;
    logic [AW+2:0] six;
    logic [AW-1:0] u;
    logic [AW:0]   v1;
    logic [63:0]   rc1;
    logic [63:0]   rc2;
    logic [30:0]   sin1;
    logic [30:0]   sin2;
    logic [61:0]   pm1;
    logic [61:0]   pm2;
    logic [15:0]   r_val;
    logic [46:0]   tm1;
    logic [46:0]   tm2;
    logic [17:0]   tsum;
    logic [16:0]   t0;
    logic [17:0]   h;
    logic [17:0]   t12h;
    logic [33:0]   da;
    logic [33:0]   db;
    logic [33:0]   dc;

    assign pop    = (state_reg == S_IDLE) && !qstat.empty;
    assign done   = done_reg;
    assign duty_a = duty_a_reg;
    assign duty_b = duty_b_reg;
    assign duty_c = duty_c_reg;
    assign sector = sector_reg;

    assign ld_zero = pop_data[0];
    assign ld_s    = pop_data[2*VW:1];
    assign ld_ang  = pop_data[2*VW+AW:2*VW+1];
    assign ld_d    = pop_data[3*VW+AW:2*VW+AW+1];
    assign ld_q    = pop_data[4*VW+AW:3*VW+AW+1];
    assign ld_x    = {{(XW-VW-8){ld_d[VW-1]}}, ld_d, 8'b0};
    assign ld_y    = {{(XW-VW-8){ld_q[VW-1]}}, ld_q, 8'b0};

    assign cnt_idx1 = cnt_reg + CW'(1);
    assign e0_sq = cnt_reg  < CW'(SQ_STEPS);
    assign e1_sq = cnt_idx1 < CW'(SQ_STEPS);
    assign e0_cd = cnt_reg  < CW'(CORDIC_STEPS);
    assign e1_cd = cnt_idx1 < CW'(CORDIC_STEPS);
    assign e0_dv = cnt_reg  < CW'(DIVN);
    assign e1_dv = cnt_idx1 < CW'(DIVN);

    assign sq0 = sqrt_step(sq_reg, rad_reg[RAD_W-1 -: 2]);
    assign sq1 = sqrt_step(sq0, rad_reg[RAD_W-3 -: 2]);
    assign at0 = atan_step(at_reg, cnt_reg[4:0]);
    assign at1 = atan_step(at0, cnt_idx1[4:0]);
    assign s10 = sin_step(sn1_reg, cnt_reg[4:0]);
    assign s11 = sin_step(s10, cnt_idx1[4:0]);
    assign s20 = sin_step(sn2_reg, cnt_reg[4:0]);
    assign s21 = sin_step(s20, cnt_idx1[4:0]);
    assign dv0 = div_step(pr_reg, dvd_reg[DIVN-1], bus_voltage);
    assign dv1 = div_step(dv0.pr, dvd_reg[DIVN-2], bus_voltage);

    assign phi_sum = at_reg.z + PHI_RND;
    assign th      = ang_reg + (zero_reg ? AW'(0) : phi_sum[31 -: AW]);
    assign six     = (AW+3)'({th, 2'b00}) + (AW+3)'({th, 1'b0});
    assign u       = six[AW-1:0];
    assign v1      = {1'b1, {AW{1'b0}}} - {1'b0, u};

    assign rc1 = y1_reg * RECIP3;
    assign rc2 = y2_reg * RECIP3;

    assign sin1 = sn1_reg.y[SW-1] ? 31'd0 : sn1_reg.y[30:0];
    assign sin2 = sn2_reg.y[SW-1] ? 31'd0 : sn2_reg.y[30:0];
    assign pm1  = sin1 * SQRT3_Q30;
    assign pm2  = sin2 * SQRT3_Q30;

    always_comb
    begin
        if (bus_voltage == '0)
        begin
            r_val = zero_reg ? 16'd0 : MOD_LIMIT;
        end
        else if (dvd_reg > DIVN'(MOD_LIMIT))
        begin
            r_val = MOD_LIMIT;
        end
        else
        begin
            r_val = dvd_reg[15:0];
        end
    end

    assign tm1 = p1_reg * r_reg;
    assign tm2 = p2_reg * r_reg;

    assign tsum = 18'(t1_reg) + 18'(t2_reg);
    assign t0   = (tsum > 18'd65536) ? 17'd0 : 17'(18'd65536 - tsum);
    assign h    = 18'(t0[16:1]);
    assign t12h = tsum + h;

    assign da = ta_reg * timer_reload;
    assign db = tb_reg * timer_reload;
    assign dc = tc_reg * timer_reload;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if ((cnt_reg + CW'(2)) >= CW'(ROOT_N))
                begin
                    state_next = S_ANG;
                end
            end
            S_ANG:  state_next = S_RECP;
            S_RECP: state_next = S_DIV;
            S_DIV:
            begin
                if ((cnt_reg + CW'(2)) >= CW'(DIVN))
                begin
                    state_next = S_M1;
                end
            end
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_OUT);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cnt_reg     <= '0;
                rad_reg     <= {ld_s, 16'b0};
                sq_reg.rem  <= '0;
                sq_reg.root <= '0;
                zero_reg    <= ld_zero;
                ang_reg     <= ld_ang;
                if (ld_d[VW-1])
                begin
                    at_reg.x <= -ld_x;
                    at_reg.y <= -ld_y;
                    at_reg.z <= 32'h80000000;
                end
                else
                begin
                    at_reg.x <= ld_x;
                    at_reg.y <= ld_y;
                    at_reg.z <= 32'd0;
                end
            end
            S_ROOT:
            begin
                cnt_reg <= cnt_reg + CW'(2);
                rad_reg <= rad_reg << 4;
                if (e1_sq)
                begin
                    sq_reg <= sq1;
                end
                else if (e0_sq)
                begin
                    sq_reg <= sq0;
                end
                if (e1_cd)
                begin
                    at_reg <= at1;
                end
                else if (e0_cd)
                begin
                    at_reg <= at0;
                end
            end
            S_ANG:
            begin
                sidx_reg <= six[AW+2:AW];
                y1_reg   <= {v1, {(31-AW){1'b0}}};
                y2_reg   <= {1'b0, u, {(31-AW){1'b0}}};
            end
            S_RECP:
            begin
                cnt_reg   <= '0;
                dvd_reg   <= {sq_reg.root, 8'b0};
                pr_reg    <= '0;
                sn1_reg.x <= $signed(SW'(CORDIC_GAIN));
                sn1_reg.y <= '0;
                sn1_reg.z <= $signed(SW'(rc1[63:33]));
                sn2_reg.x <= $signed(SW'(CORDIC_GAIN));
                sn2_reg.y <= '0;
                sn2_reg.z <= $signed(SW'(rc2[63:33]));
            end
            S_DIV:
            begin
                cnt_reg <= cnt_reg + CW'(2);
                if (e1_dv)
                begin
                    pr_reg  <= dv1.pr;
                    dvd_reg <= {dvd_reg[DIVN-3:0], dv0.qbit, dv1.qbit};
                end
                else if (e0_dv)
                begin
                    pr_reg  <= dv0.pr;
                    dvd_reg <= {dvd_reg[DIVN-2:0], dv0.qbit};
                end
                if (e1_cd)
                begin
                    sn1_reg <= s11;
                    sn2_reg <= s21;
                end
                else if (e0_cd)
                begin
                    sn1_reg <= s10;
                    sn2_reg <= s20;
                end
            end
            S_M1:
            begin
                p1_reg <= pm1[60:30];
                p2_reg <= pm2[60:30];
                r_reg  <= r_val;
            end
            S_M2:
            begin
                t1_reg <= tm1[46:30];
                t2_reg <= tm2[46:30];
            end
            S_M3:
            begin
                case (sidx_reg)
                    3'd0:
                    begin
                        ta_reg <= t12h;
                        tb_reg <= 18'(t2_reg) + h;
                        tc_reg <= h;
                    end
                    3'd1:
                    begin
                        ta_reg <= 18'(t1_reg) + h;
                        tb_reg <= t12h;
                        tc_reg <= h;
                    end
                    3'd2:
                    begin
                        ta_reg <= h;
                        tb_reg <= t12h;
                        tc_reg <= 18'(t2_reg) + h;
                    end
                    3'd3:
                    begin
                        ta_reg <= h;
                        tb_reg <= 18'(t1_reg) + h;
                        tc_reg <= t12h;
                    end
                    3'd4:
                    begin
                        ta_reg <= 18'(t2_reg) + h;
                        tb_reg <= h;
                        tc_reg <= t12h;
                    end
                    default:
                    begin
                        ta_reg <= t12h;
                        tb_reg <= h;
                        tc_reg <= 18'(t1_reg) + h;
                    end
                endcase
            end
            S_OUT:
            begin
                duty_a_reg <= da[31:16];
                duty_b_reg <= db[31:16];
                duty_c_reg <= dc[31:16];
                sector_reg <= sidx_reg + 3'd1;
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule

`default_nettype wire
